// ===== hdl/assert_macros.svh =====
// assertion macros shared by the translation engine
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every clock edge out of reset
`define ASSERT_HOLDS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// antecedent in one cycle implies consequent in the next
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/bmft_pkg.sv =====
// types and constants of the block mapped flash translation engine
`timescale 1ns / 1ps
package bmft_pkg;

  localparam int PAGES_IN_BLOCK = 8;
  localparam int PHYS_BLOCKS    = 64;
  localparam int LOGICAL_BLOCKS = 63;

  localparam int PAGE_W = $clog2(PAGES_IN_BLOCK);
  localparam int BLK_W  = $clog2(PHYS_BLOCKS);
  localparam int LB_W   = $clog2(LOGICAL_BLOCKS);
  localparam int ADDR_W = BLK_W + PAGE_W;
  localparam int SEC_W  = 9;
  localparam int CNT_W  = $clog2(PHYS_BLOCKS + 1);
  localparam int FILL_W = $clog2(PAGES_IN_BLOCK + 1);
  localparam int OP_W   = 3;

  typedef enum logic [OP_W-1:0] {
    OP_READ      = 3'd0,
    OP_PROGRAM   = 3'd1,
    OP_COPY      = 3'd2,
    OP_ERASE     = 3'd3,
    OP_NOT_FOUND = 3'd4,
    OP_NO_FREE   = 3'd5
  } op_t;

  typedef enum logic {
    CMD_READ  = 1'b0,
    CMD_WRITE = 1'b1
  } cmd_t;

  typedef enum logic [3:0] {
    S_IDLE, S_CHECK, S_MAP, S_RSCAN, S_RCMP, S_POPW,
    S_POPM, S_MRD, S_MCMP, S_MPROG, S_MERASE
  } state_t;

  typedef struct packed {
    logic             command;
    logic [SEC_W-1:0] logical_sector;
  } req_t;

  typedef struct packed {
    logic [OP_W-1:0]   operation;
    logic [ADDR_W-1:0] source_page;
    logic [ADDR_W-1:0] target_page;
    logic [BLK_W-1:0]  erase_block;
    logic              last;
  } res_t;

  typedef struct packed {
    logic             command;
    logic [SEC_W-1:0] sector;
    logic [LB_W-1:0]  lb;
    logic             out_range;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } head_t;

endpackage

// ===== hdl/block_mapped_flash_translation.sv =====
// top level of the block mapped flash translation engine
`timescale 1ns / 1ps
// Takes read or write requests for a logical sector (start while busy is low) and emits
// flash commands as words marked by out_strobe; the receiver cannot stall and the last
// command of a request carries last. A read scans the mapped block's page tags from the
// newest page down, reading the page tag memory once per page; a write programs the next
// page, first mapping a free block if needed, or merges a full 8-page block by copying
// its live pages, programming the new sector and erasing the old block. Two requests can
// be queued ahead of the engine. No clearing pass is needed after reset.
module block_mapped_flash_translation (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  output logic           busy,
  input  bmft_pkg::req_t in_word,
  output logic           out_strobe,
  output bmft_pkg::res_t out_word
);

  bmft_pkg::head_t head;
  logic            pop;

  bmft_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .busy    (busy),
    .in_word (in_word),
    .head    (head),
    .pop     (pop)
  );

  bmft_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .pop        (pop),
    .out_strobe (out_strobe),
    .out_word   (out_word)
  );

endmodule

// ===== hdl/bmft_front.sv =====
// request intake: classifies words and queues them for the engine
`timescale 1ns / 1ps
module bmft_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  output logic            busy,
  input  bmft_pkg::req_t  in_word,
  output bmft_pkg::head_t head,
  input  logic            pop
);

  localparam int DEPTH = 2;

  bmft_pkg::item_t q_r [DEPTH];
  logic            wp_r, wp_nxt;
  logic            rp_r, rp_nxt;
  logic [1:0]      cnt_r, cnt_nxt;
  logic            push;
  logic            do_pop;
  bmft_pkg::item_t cls;

  always_comb begin
    cls.command   = in_word.command;
    cls.sector    = in_word.logical_sector;
    cls.lb        = bmft_pkg::LB_W'(in_word.logical_sector >> bmft_pkg::PAGE_W);
    cls.out_range = (in_word.logical_sector >> bmft_pkg::PAGE_W) >=
                    bmft_pkg::SEC_W'(bmft_pkg::LOGICAL_BLOCKS);
  end

  assign busy   = (cnt_r == 2'(DEPTH));
  assign push   = start && !busy;
  assign do_pop = pop && (cnt_r != 2'd0);

  assign head.valid = (cnt_r != 2'd0);
  assign head.item  = q_r[rp_r];

  always_comb begin
    wp_nxt  = push ? !wp_r : wp_r;
    rp_nxt  = do_pop ? !rp_r : rp_r;
    cnt_nxt = cnt_r + 2'(push) - 2'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wp_r] <= cls;
    end
  end

endmodule

// ===== hdl/bmft_back.sv =====
// translation engine: map, free stack, page tags and command sequencing
`timescale 1ns / 1ps
`include "assert_macros.svh"
module bmft_back (
  input  logic            clk,
  input  logic            rst_n,
  input  bmft_pkg::head_t head,
  output logic            pop,
  output logic            out_strobe,
  output bmft_pkg::res_t  out_word
);

  localparam int P  = bmft_pkg::PAGES_IN_BLOCK;
  localparam int NB = bmft_pkg::PHYS_BLOCKS;
  localparam int NL = bmft_pkg::LOGICAL_BLOCKS;

  // memories
  logic [bmft_pkg::BLK_W-1:0]  map_blk_mem  [NL];
  logic [bmft_pkg::FILL_W-1:0] map_fill_mem [NL];
  logic [bmft_pkg::BLK_W-1:0]  stack_mem    [NB];
  logic [bmft_pkg::SEC_W-1:0]  tag_mem      [NB*P];

  bmft_pkg::state_t state_r, state_nxt;
  bmft_pkg::item_t  req_r, req_nxt;

  logic [NL-1:0]               map_valid_r;
  logic [NB-1:0]               stk_valid_r;
  logic [bmft_pkg::CNT_W-1:0]  fc_r, fc_nxt;
  logic [bmft_pkg::FILL_W-1:0] i_r, i_nxt;
  logic [bmft_pkg::FILL_W-1:0] used_r, used_nxt;
  logic [bmft_pkg::BLK_W-1:0]  nb_r, nb_nxt;
  logic [bmft_pkg::SEC_W-1:0]  seen_tag_r [P];
  logic [P-1:0]                seen_v_r, seen_v_nxt;
  logic                        seen_we;

  logic [bmft_pkg::BLK_W-1:0]  mb_rd_r;
  logic [bmft_pkg::FILL_W-1:0] fill_rd_r;
  logic [bmft_pkg::BLK_W-1:0]  stk_rd_r;
  logic [bmft_pkg::BLK_W-1:0]  stk_idx_r;
  logic                        stk_hit_r;
  logic [bmft_pkg::SEC_W-1:0]  tag_rd_r;

  logic                         out_strobe_r;
  bmft_pkg::res_t               out_word_r;
  logic                         emit;
  bmft_pkg::res_t               emit_word;

  logic                         tag_we;
  logic [bmft_pkg::ADDR_W-1:0]  tag_waddr;
  logic [bmft_pkg::SEC_W-1:0]   tag_wdata;
  logic [bmft_pkg::ADDR_W-1:0]  tag_raddr;
  logic                         blk_we;
  logic [bmft_pkg::BLK_W-1:0]   blk_wdata;
  logic                         fill_we;
  logic [bmft_pkg::FILL_W-1:0]  fill_wdata;
  logic                         set_valid;
  logic                         push;

  logic [bmft_pkg::PAGE_W-1:0]  i_lo;
  logic [bmft_pkg::PAGE_W-1:0]  fill_lo;
  logic [bmft_pkg::PAGE_W-1:0]  used_lo;
  logic [bmft_pkg::BLK_W-1:0]   stk_val;
  logic [bmft_pkg::BLK_W-1:0]   stk_ridx;
  logic                         mvalid;
  logic                         keep;

  assign i_lo     = bmft_pkg::PAGE_W'(i_r - bmft_pkg::FILL_W'(1));
  assign fill_lo  = fill_rd_r[bmft_pkg::PAGE_W-1:0];
  assign used_lo  = used_r[bmft_pkg::PAGE_W-1:0];
  assign mvalid   = map_valid_r[req_r.lb];
  assign stk_ridx = bmft_pkg::BLK_W'(fc_r - bmft_pkg::CNT_W'(1));
  assign stk_val  = stk_hit_r ? stk_rd_r :
                    bmft_pkg::BLK_W'(NB - 1) - stk_idx_r;
  assign tag_raddr = {mb_rd_r, i_lo};

  always_comb begin
    keep = (tag_rd_r != req_r.sector);
    for (int k = 0; k < P; k++) begin
      if (seen_v_r[k] && seen_tag_r[k] == tag_rd_r) begin
        keep = 1'b0;
      end
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      bmft_pkg::S_IDLE:   if (head.valid) state_nxt = bmft_pkg::S_CHECK;
      bmft_pkg::S_CHECK:  state_nxt = req_r.out_range ? bmft_pkg::S_IDLE : bmft_pkg::S_MAP;
      bmft_pkg::S_MAP: begin
        if (req_r.command == bmft_pkg::CMD_READ) begin
          state_nxt = (mvalid && fill_rd_r != '0) ? bmft_pkg::S_RSCAN : bmft_pkg::S_IDLE;
        end else if (!mvalid) begin
          state_nxt = (fc_r == '0) ? bmft_pkg::S_IDLE : bmft_pkg::S_POPW;
        end else if (fill_rd_r < bmft_pkg::FILL_W'(P)) begin
          state_nxt = bmft_pkg::S_IDLE;
        end else begin
          state_nxt = (fc_r == '0) ? bmft_pkg::S_IDLE : bmft_pkg::S_POPM;
        end
      end
      bmft_pkg::S_RSCAN:  state_nxt = bmft_pkg::S_RCMP;
      bmft_pkg::S_RCMP: begin
        state_nxt = (tag_rd_r == req_r.sector || i_r == bmft_pkg::FILL_W'(1)) ?
                    bmft_pkg::S_IDLE : bmft_pkg::S_RSCAN;
      end
      bmft_pkg::S_POPW:   state_nxt = bmft_pkg::S_IDLE;
      bmft_pkg::S_POPM:   state_nxt = bmft_pkg::S_MRD;
      bmft_pkg::S_MRD:    state_nxt = bmft_pkg::S_MCMP;
      bmft_pkg::S_MCMP: begin
        state_nxt = (i_r == bmft_pkg::FILL_W'(1)) ? bmft_pkg::S_MPROG : bmft_pkg::S_MRD;
      end
      bmft_pkg::S_MPROG:  state_nxt = bmft_pkg::S_MERASE;
      bmft_pkg::S_MERASE: state_nxt = bmft_pkg::S_IDLE;
      default:            state_nxt = bmft_pkg::S_IDLE;
    endcase
  end

  // outputs and datapath controls
  always_comb begin
    pop        = 1'b0;
    req_nxt    = req_r;
    emit       = 1'b0;
    emit_word  = '0;
    tag_we     = 1'b0;
    tag_waddr  = '0;
    tag_wdata  = req_r.sector;
    blk_we     = 1'b0;
    blk_wdata  = nb_r;
    fill_we    = 1'b0;
    fill_wdata = '0;
    set_valid  = 1'b0;
    push       = 1'b0;
    fc_nxt     = fc_r;
    i_nxt      = i_r;
    used_nxt   = used_r;
    nb_nxt     = nb_r;
    seen_v_nxt = seen_v_r;
    seen_we    = 1'b0;
    unique case (state_r)
      bmft_pkg::S_IDLE: begin
        pop     = head.valid;
        req_nxt = head.item;
      end
      bmft_pkg::S_CHECK: begin
        if (req_r.out_range) begin
          emit                = 1'b1;
          emit_word.operation = bmft_pkg::OP_NOT_FOUND;
          emit_word.last      = 1'b1;
        end
      end
      bmft_pkg::S_MAP: begin
        if (req_r.command == bmft_pkg::CMD_READ) begin
          if (!mvalid || fill_rd_r == '0) begin
            emit                = 1'b1;
            emit_word.operation = bmft_pkg::OP_NOT_FOUND;
            emit_word.last      = 1'b1;
          end
          i_nxt = fill_rd_r;
        end else if (!mvalid || fill_rd_r >= bmft_pkg::FILL_W'(P)) begin
          if (fc_r == '0) begin
            emit                = 1'b1;
            emit_word.operation = bmft_pkg::OP_NO_FREE;
            emit_word.last      = 1'b1;
          end
        end else begin
          tag_we                = 1'b1;
          tag_waddr             = {mb_rd_r, fill_lo};
          fill_we               = 1'b1;
          fill_wdata            = fill_rd_r + bmft_pkg::FILL_W'(1);
          emit                  = 1'b1;
          emit_word.operation   = bmft_pkg::OP_PROGRAM;
          emit_word.target_page = {mb_rd_r, fill_lo};
          emit_word.last        = 1'b1;
        end
      end
      bmft_pkg::S_RSCAN: begin
      end
      bmft_pkg::S_RCMP: begin
        if (tag_rd_r == req_r.sector) begin
          emit                  = 1'b1;
          emit_word.operation   = bmft_pkg::OP_READ;
          emit_word.source_page = {mb_rd_r, i_lo};
          emit_word.last        = 1'b1;
        end else if (i_r == bmft_pkg::FILL_W'(1)) begin
          emit                = 1'b1;
          emit_word.operation = bmft_pkg::OP_NOT_FOUND;
          emit_word.last      = 1'b1;
        end
        i_nxt = i_r - bmft_pkg::FILL_W'(1);
      end
      bmft_pkg::S_POPW: begin
        fc_nxt                = fc_r - bmft_pkg::CNT_W'(1);
        blk_we                = 1'b1;
        blk_wdata             = stk_val;
        fill_we               = 1'b1;
        fill_wdata            = bmft_pkg::FILL_W'(1);
        set_valid             = 1'b1;
        tag_we                = 1'b1;
        tag_waddr             = {stk_val, bmft_pkg::PAGE_W'(0)};
        emit                  = 1'b1;
        emit_word.operation   = bmft_pkg::OP_PROGRAM;
        emit_word.target_page = {stk_val, bmft_pkg::PAGE_W'(0)};
        emit_word.last        = 1'b1;
      end
      bmft_pkg::S_POPM: begin
        nb_nxt     = stk_val;
        fc_nxt     = fc_r - bmft_pkg::CNT_W'(1);
        i_nxt      = bmft_pkg::FILL_W'(P);
        used_nxt   = '0;
        seen_v_nxt = '0;
      end
      bmft_pkg::S_MRD: begin
      end
      bmft_pkg::S_MCMP: begin
        seen_we          = 1'b1;
        seen_v_nxt[i_lo] = 1'b1;
        if (keep && used_r < bmft_pkg::FILL_W'(P - 1)) begin
          tag_we                = 1'b1;
          tag_waddr             = {nb_r, used_lo};
          tag_wdata             = tag_rd_r;
          emit                  = 1'b1;
          emit_word.operation   = bmft_pkg::OP_COPY;
          emit_word.source_page = {mb_rd_r, i_lo};
          emit_word.target_page = {nb_r, used_lo};
          used_nxt              = used_r + bmft_pkg::FILL_W'(1);
        end
        i_nxt = i_r - bmft_pkg::FILL_W'(1);
      end
      bmft_pkg::S_MPROG: begin
        tag_we                = 1'b1;
        tag_waddr             = {nb_r, used_lo};
        emit                  = 1'b1;
        emit_word.operation   = bmft_pkg::OP_PROGRAM;
        emit_word.target_page = {nb_r, used_lo};
      end
      bmft_pkg::S_MERASE: begin
        emit                  = 1'b1;
        emit_word.operation   = bmft_pkg::OP_ERASE;
        emit_word.erase_block = mb_rd_r;
        emit_word.last        = 1'b1;
        push                  = (fc_r < bmft_pkg::CNT_W'(NB));
        fc_nxt                = push ? fc_r + bmft_pkg::CNT_W'(1) : fc_r;
        blk_we                = 1'b1;
        fill_we               = 1'b1;
        fill_wdata            = used_r + bmft_pkg::FILL_W'(1);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= bmft_pkg::S_IDLE;
      map_valid_r  <= '0;
      stk_valid_r  <= '0;
      fc_r         <= bmft_pkg::CNT_W'(NB);
      out_strobe_r <= 1'b0;
      seen_v_r     <= '0;
    end else begin
      state_r      <= state_nxt;
      fc_r         <= fc_nxt;
      out_strobe_r <= emit;
      seen_v_r     <= seen_v_nxt;
      if (set_valid) begin
        map_valid_r[req_r.lb] <= 1'b1;
      end
      if (push) begin
        stk_valid_r[fc_r[bmft_pkg::BLK_W-1:0]] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    req_r      <= req_nxt;
    i_r        <= i_nxt;
    used_r     <= used_nxt;
    nb_r       <= nb_nxt;
    out_word_r <= emit_word;
    if (seen_we) begin
      seen_tag_r[i_lo] <= tag_rd_r;
    end
  end

  // map memories
  always_ff @(posedge clk) begin
    if (blk_we) begin
      map_blk_mem[req_r.lb] <= blk_wdata;
    end
    if (fill_we) begin
      map_fill_mem[req_r.lb] <= fill_wdata;
    end
    mb_rd_r   <= map_blk_mem[req_r.lb];
    fill_rd_r <= map_fill_mem[req_r.lb];
  end

  // free block stack
  always_ff @(posedge clk) begin
    if (push) begin
      stack_mem[fc_r[bmft_pkg::BLK_W-1:0]] <= mb_rd_r;
    end
    stk_rd_r  <= stack_mem[stk_ridx];
    stk_idx_r <= stk_ridx;
    stk_hit_r <= stk_valid_r[stk_ridx];
  end

  // page tag shadow
  always_ff @(posedge clk) begin
    if (tag_we) begin
      tag_mem[tag_waddr] <= tag_wdata;
    end
    tag_rd_r <= tag_mem[tag_raddr];
  end

  assign out_strobe = out_strobe_r;
  assign out_word   = out_word_r;

  `ASSERT_HOLDS(a_fc_range, fc_r <= bmft_pkg::CNT_W'(NB), "free count above block count")
  `ASSERT_NEXT(a_idle_quiet, state_r == bmft_pkg::S_IDLE, !out_strobe_r, "word from idle engine")
  `ASSERT_NEXT(a_erase_push, state_r == bmft_pkg::S_MERASE, fc_r == $past(fc_r) + bmft_pkg::CNT_W'(1), "erased block not returned to stack")

endmodule
